[rtl/core/ffea_pkg.sv]
package ffea_pkg;

	localparam int ADDR_BITS    = 16;
	localparam int LEN_BITS     = ADDR_BITS + 1;
	localparam int MAX_EXTENTS  = 32;
	localparam int IDX_BITS     = $clog2(MAX_EXTENTS);
	localparam int CNT_BITS     = $clog2(MAX_EXTENTS + 1);
	localparam int HEADER_BYTES = 4;

	localparam logic [LEN_BITS-1:0] POOL_MAX = LEN_BITS'(1) << ADDR_BITS;
	localparam logic [LEN_BITS-1:0] LEN_MAX  = '1;
	localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(MAX_EXTENTS);

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_ZERO    = 3'd1;
	localparam logic [2:0] ST_NOFIT   = 3'd2;
	localparam logic [2:0] ST_BAD_OFF = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;

	typedef struct packed {
		logic                 mode;
		logic [15:0]          size;
		logic [15:0]          offset;
	} req_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [15:0]          user_offset;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] start;
		logic [LEN_BITS-1:0]  len;
	} extent_t;

	function automatic logic [LEN_BITS-1:0] sat_len(input logic [LEN_BITS:0] v);
		return v[LEN_BITS] ? LEN_MAX : v[LEN_BITS-1:0];
	endfunction

	function automatic logic [LEN_BITS-1:0] clamp_pool(input logic [16:0] v);
		return (LEN_BITS'(v) > POOL_MAX) ? POOL_MAX : LEN_BITS'(v);
	endfunction

endpackage

[rtl/core/first_fit_extent_allocator_unit.sv]
// channel   signals                     transaction when
// req       req_valid req_ready req     req_valid && req_ready
// rsp       rsp_valid rsp_ready rsp     rsp_valid && rsp_ready
// cfg       cfg_we cfg_wdata            cfg_we
// a request with zero size or a bad offset is answered from idle without a scan; else the extents
// are scanned in order, and entries are moved on remove or insert
// the free table sits in one registered-read memory; scan and shift share its read port
// after reset, S_INIT loads entry 0 with the whole pool; a cfg write reloads it at once
// req_ready stays low while a request is at work or a response waits
module first_fit_extent_allocator_unit import ffea_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_t        rsp,
	input  logic        cfg_we,
	input  logic [16:0] cfg_wdata
);

	typedef enum logic [6:0] {
		S_INIT  = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_RD    = 7'b0000100,
		S_CHK   = 7'b0001000,
		S_SHIFT = 7'b0010000,
		S_FIN   = 7'b0100000,
		S_SPARE = 7'b1000000
	} state_t;

	state_t                state_q;
	extent_t               mem [MAX_EXTENTS];
	extent_t               rdata_q;
	logic [LEN_BITS-1:0]   pool_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [CNT_BITS-1:0]   idx_q;
	logic                  mode_q;
	logic [LEN_BITS-1:0]   need_q;
	logic [ADDR_BITS-1:0]  real_q;
	extent_t               pred_q;
	logic [CNT_BITS-1:0]   sh_rd_q;
	logic [CNT_BITS-1:0]   sh_n_q;
	logic                  sh_up_q;
	logic                  pend_q;
	logic [IDX_BITS-1:0]   wa_q;
	logic                  fin_ins_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic                  we;
	logic [IDX_BITS-1:0]   wa;
	extent_t               wd;
	logic [IDX_BITS-1:0]   ra;

	logic                  has_succ, free_go, jp, js, merge_succ, fit, exact;
	logic [LEN_BITS:0]     p_end, p_end2, s_end;
	logic [LEN_BITS-1:0]   nl, nl2;
	logic [CNT_BITS-1:0]   idx_m1;

	assign req_ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign idx_m1    = idx_q - CNT_BITS'(1);

	assign has_succ   = (state_q == S_CHK);
	assign free_go    = mode_q && (((state_q == S_RD) && (idx_q == cnt_q)) ||
		((state_q == S_CHK) && (rdata_q.start > real_q)));
	assign p_end      = (LEN_BITS+1)'(pred_q.start) + (LEN_BITS+1)'(pred_q.len);
	assign jp         = (idx_q != '0) && (p_end == (LEN_BITS+1)'(real_q));
	assign nl         = sat_len((LEN_BITS+1)'(pred_q.len) + (LEN_BITS+1)'(need_q));
	assign p_end2     = (LEN_BITS+1)'(pred_q.start) + (LEN_BITS+1)'(nl);
	assign merge_succ = has_succ && (p_end2 == (LEN_BITS+1)'(rdata_q.start));
	assign nl2        = sat_len((LEN_BITS+1)'(nl) + (LEN_BITS+1)'(rdata_q.len));
	assign s_end      = (LEN_BITS+1)'(real_q) + (LEN_BITS+1)'(need_q);
	assign js         = has_succ && (s_end == (LEN_BITS+1)'(rdata_q.start));
	assign fit        = rdata_q.len >= need_q;
	assign exact      = rdata_q.len == need_q;

	always_comb begin
		ra = (state_q == S_SHIFT) ? sh_rd_q[IDX_BITS-1:0] : idx_q[IDX_BITS-1:0];
		we = 1'b0;
		wa = '0;
		wd = '0;
		if (cfg_we) begin
			we = 1'b1;
			wd = '{start: '0, len: clamp_pool(cfg_wdata)};
		end else begin
			case (state_q)
				S_INIT: begin
					we = 1'b1;
					wd = '{start: '0, len: pool_q};
				end
				S_RD, S_CHK: begin
					if (state_q == S_CHK && !mode_q && fit && !exact) begin
						we = 1'b1;
						wa = idx_q[IDX_BITS-1:0];
						wd = '{start: rdata_q.start + ADDR_BITS'(need_q),
							len: rdata_q.len - need_q};
					end else if (free_go && jp) begin
						we = 1'b1;
						wa = idx_m1[IDX_BITS-1:0];
						wd = '{start: pred_q.start, len: merge_succ ? nl2 : nl};
					end else if (free_go && js) begin
						we = 1'b1;
						wa = idx_q[IDX_BITS-1:0];
						wd = '{start: real_q,
							len: sat_len((LEN_BITS+1)'(need_q) + (LEN_BITS+1)'(rdata_q.len))};
					end
				end
				S_SHIFT: begin
					we = pend_q;
					wa = wa_q;
					wd = rdata_q;
				end
				S_FIN: begin
					we = fin_ins_q;
					wa = idx_q[IDX_BITS-1:0];
					wd = '{start: real_q, len: need_q};
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		rdata_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			pool_q      <= POOL_MAX;
			cnt_q       <= CNT_BITS'(1);
			rsp_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready)
				rsp_valid_q <= 1'b0;
			if (cfg_we) begin
				pool_q <= clamp_pool(cfg_wdata);
				cnt_q  <= CNT_BITS'(1);
			end
			case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_valid && req_ready) begin
						mode_q <= req.mode;
						need_q <= LEN_BITS'(req.size) + LEN_BITS'(HEADER_BYTES);
						real_q <= req.offset - ADDR_BITS'(HEADER_BYTES);
						idx_q  <= '0;
						if (req.size == '0) begin
							rsp_valid_q <= 1'b1;
							rsp_q       <= '{status: ST_ZERO, user_offset: '0};
						end else if (req.mode && req.offset < 16'(HEADER_BYTES)) begin
							rsp_valid_q <= 1'b1;
							rsp_q       <= '{status: ST_BAD_OFF, user_offset: '0};
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD, S_CHK: begin
					if (state_q == S_RD && !free_go) begin
						if (idx_q == cnt_q) begin
							rsp_valid_q <= 1'b1;
							rsp_q       <= '{status: ST_NOFIT, user_offset: '0};
							state_q     <= S_IDLE;
						end else begin
							state_q <= S_CHK;
						end
					end else if (state_q == S_CHK && !mode_q) begin
						if (fit) begin
							rsp_q <= '{status: ST_OK,
								user_offset: rdata_q.start + 16'(HEADER_BYTES)};
							if (exact) begin
								sh_rd_q   <= idx_q + CNT_BITS'(1);
								sh_n_q    <= cnt_q - idx_q - CNT_BITS'(1);
								sh_up_q   <= 1'b0;
								fin_ins_q <= 1'b0;
								state_q   <= S_SHIFT;
							end else begin
								rsp_valid_q <= 1'b1;
								state_q     <= S_IDLE;
							end
						end else begin
							idx_q   <= idx_q + CNT_BITS'(1);
							state_q <= S_RD;
						end
					end else if (!free_go) begin
						pred_q  <= rdata_q;
						idx_q   <= idx_q + CNT_BITS'(1);
						state_q <= S_RD;
					end else begin
						rsp_q <= '{status: ST_OK, user_offset: '0};
						if (jp && merge_succ) begin
							sh_rd_q   <= idx_q + CNT_BITS'(1);
							sh_n_q    <= cnt_q - idx_q - CNT_BITS'(1);
							sh_up_q   <= 1'b0;
							fin_ins_q <= 1'b0;
							state_q   <= S_SHIFT;
						end else if (jp || js) begin
							rsp_valid_q <= 1'b1;
							state_q     <= S_IDLE;
						end else if (cnt_q >= CNT_FULL) begin
							rsp_valid_q <= 1'b1;
							rsp_q       <= '{status: ST_FULL, user_offset: '0};
							state_q     <= S_IDLE;
						end else begin
							sh_rd_q   <= cnt_q - CNT_BITS'(1);
							sh_n_q    <= cnt_q - idx_q;
							sh_up_q   <= 1'b1;
							fin_ins_q <= 1'b1;
							state_q   <= S_SHIFT;
						end
					end
				end
				S_SHIFT: begin
					if (sh_n_q != '0) begin
						pend_q  <= 1'b1;
						wa_q    <= sh_up_q ? IDX_BITS'(sh_rd_q + CNT_BITS'(1))
							: IDX_BITS'(sh_rd_q - CNT_BITS'(1));
						sh_rd_q <= sh_up_q ? sh_rd_q - CNT_BITS'(1) : sh_rd_q + CNT_BITS'(1);
						sh_n_q  <= sh_n_q - CNT_BITS'(1);
					end else begin
						pend_q <= 1'b0;
						if (!pend_q)
							state_q <= S_FIN;
					end
				end
				S_FIN: begin
					cnt_q       <= fin_ins_q ? cnt_q + CNT_BITS'(1) : cnt_q - CNT_BITS'(1);
					rsp_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/ffea_checker.sv]
module ffea_checker import ffea_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input rsp_t        rsp
);

	// one request in flight at a time
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another in flight");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status <= ST_FULL))
		else $error("status code out of range");

	a_err_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.user_offset == '0)
		else $error("error response carries an offset");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

endmodule

bind first_fit_extent_allocator_unit ffea_checker u_ffea_checker (.*);

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import ffea_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	class alloc_scoreboard;
		logic [LEN_BITS-1:0]  pool;
		logic [ADDR_BITS-1:0] ext_start [MAX_EXTENTS];
		logic [LEN_BITS-1:0]  ext_len [MAX_EXTENTS];
		int                   ext_count;
		rsp_t                 pending [$];
		int                   errors;
		int                   checked;

		function new();
			errors = 0;
			checked = 0;
			set_pool(17'h10000);
		endfunction

		function void set_pool(logic [16:0] v);
			pool = (v > POOL_MAX) ? POOL_MAX : v;
			foreach (ext_start[k]) begin
				ext_start[k] = '0;
				ext_len[k] = '0;
			end
			ext_len[0] = pool;
			ext_count = 1;
		endfunction

		function logic [LEN_BITS-1:0] clip(longint v);
			return (v > longint'(LEN_MAX)) ? LEN_MAX : v[LEN_BITS-1:0];
		endfunction

		function void drop_entry(int i);
			for (int k = i; k + 1 < ext_count; k++) begin
				ext_start[k] = ext_start[k + 1];
				ext_len[k] = ext_len[k + 1];
			end
			ext_count--;
			ext_start[ext_count] = '0;
			ext_len[ext_count] = '0;
		endfunction

		function rsp_t first_fit(longint sz);
			rsp_t r;
			longint need;
			r = '{status: ST_NOFIT, user_offset: '0};
			need = sz + HEADER_BYTES;
			for (int i = 0; i < ext_count; i++) begin
				if (ext_len[i] >= need) begin
					r.status = ST_OK;
					r.user_offset = 16'(ext_start[i] + HEADER_BYTES);
					if (ext_len[i] == need) drop_entry(i);
					else begin
						ext_start[i] = ADDR_BITS'(ext_start[i] + need);
						ext_len[i] = ext_len[i] - LEN_BITS'(need);
					end
					return r;
				end
			end
			return r;
		endfunction

		function logic [2:0] give_back(longint sz, longint off);
			longint real_start, len;
			int pos, p;
			if (off < HEADER_BYTES) return ST_BAD_OFF;
			real_start = off - HEADER_BYTES;
			len = sz + HEADER_BYTES;
			pos = 0;
			while (pos < ext_count && ext_start[pos] <= real_start) pos++;
			if (pos > 0 && longint'(ext_start[pos-1]) + ext_len[pos-1] == real_start) begin
				p = pos - 1;
				ext_len[p] = clip(longint'(ext_len[p]) + len);
				if (pos < ext_count &&
						longint'(ext_start[p]) + ext_len[p] == ext_start[pos]) begin
					ext_len[p] = clip(longint'(ext_len[p]) + ext_len[pos]);
					drop_entry(pos);
				end
				return ST_OK;
			end
			if (pos < ext_count && real_start + len == ext_start[pos]) begin
				ext_start[pos] = real_start[ADDR_BITS-1:0];
				ext_len[pos] = clip(len + ext_len[pos]);
				return ST_OK;
			end
			if (ext_count >= MAX_EXTENTS) return ST_FULL;
			for (int k = ext_count; k > pos; k--) begin
				ext_start[k] = ext_start[k - 1];
				ext_len[k] = ext_len[k - 1];
			end
			ext_start[pos] = real_start[ADDR_BITS-1:0];
			ext_len[pos] = clip(len);
			ext_count++;
			return ST_OK;
		endfunction

		function void note_request(req_t q);
			rsp_t r;
			r = '{status: ST_OK, user_offset: '0};
			if (q.size == 0) r.status = ST_ZERO;
			else if (!q.mode) r = first_fit(longint'(q.size));
			else r.status = give_back(longint'(q.size), longint'(q.offset));
			if (r.status != ST_OK) r.user_offset = '0;
			pending.push_back(r);
		endfunction

		task check_response(rsp_t got);
			rsp_t want;
			checked++;
			if (pending.size() == 0) begin
				report("response with nothing outstanding", 0, 0);
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status)
				report("status", longint'(got.status), longint'(want.status));
			if (got.user_offset !== want.user_offset)
				report("user_offset", longint'(got.user_offset), longint'(want.user_offset));
		endtask

		task report(string what, longint got, longint want);
			errors++;
			$display("mismatch on %s: got %0d, expected %0d", what, got, want);
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	req_t        req;
	logic        rsp_valid;
	logic        rsp_ready;
	rsp_t        rsp;
	logic        cfg_we;
	logic [16:0] cfg_wdata;

	alloc_scoreboard sb;
	int  send_gap_pct;
	int  stall_pct;
	int  idle_cycles;
	int  sent;
	logic [15:0] live_off [$];
	logic [15:0] live_size [$];

	first_fit_extent_allocator_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				sb.check_response(rsp);
				// remember successful allocations for later frees
				if (rsp.status == ST_OK && rsp.user_offset != 0) live_off.push_back(rsp.user_offset);
			end
			rsp_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("stalled for %0d cycles", IDLE_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send(req_t q);
		if ($urandom_range(99) < send_gap_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
		end
		req_valid <= 1'b1;
		req <= q;
		do @(posedge clk); while (!req_ready);
		sb.note_request(q);
		if (!q.mode && q.size != 0) live_size.push_back(q.size);
		sent++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_pool(logic [16:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_pool(v);
		live_off.delete();
		live_size.delete();
	endtask

	function automatic req_t make(logic m, logic [15:0] s, logic [15:0] o);
		req_t q;
		q.mode = m;
		q.size = s;
		q.offset = o;
		return q;
	endfunction

	// mostly well-formed alloc/free traffic with some noise
	task automatic random_phase(int count, int gap, int stall, int max_sz);
		int pick, j;
		logic [15:0] o, s;
		send_gap_pct = gap;
		stall_pct = stall;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 50) send(make(1'b0, 16'($urandom_range(max_sz, 1)), 16'($urandom)));
			else if (pick < 85 && live_off.size() != 0) begin
				drain();
				j = $urandom_range(live_off.size() - 1);
				o = live_off[j];
				s = (j < live_size.size()) ? live_size[j] : 16'($urandom_range(max_sz, 1));
				live_off.delete(j);
				send(make(1'b1, s, o));
			end
			else if (pick < 93) send(make(1'b1, 16'($urandom_range(max_sz, 1)), 16'($urandom)));
			else send(make(1'($urandom_range(1)), 16'($urandom), 16'($urandom)));
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		send_gap_pct = 0;
		stall_pct = 0;
		idle_cycles = 0;
		sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		send(make(1'b0, 16'd0, 16'd0));
		send(make(1'b1, 16'd0, 16'hffff));
		send(make(1'b0, 16'd100, 16'hffff));
		send(make(1'b0, 16'd200, 16'd0));
		send(make(1'b1, 16'd100, 16'd4));
		send(make(1'b1, 16'd200, 16'd108));
		send(make(1'b1, 16'd5, 16'd3));
		send(make(1'b1, 16'd5, 16'd0));
		send(make(1'b0, 16'hffff, 16'd0));
		send(make(1'b0, 16'hfffc, 16'd0));
		send(make(1'b0, 16'd1, 16'd0));
		send(make(1'b1, 16'hfffc, 16'd4));
		send(make(1'b1, 16'hffff, 16'hffff));
		send(make(1'b1, 16'hffff, 16'h8000));
		for (int k = 0; k < 34; k++) send(make(1'b1, 16'd1, 16'(100 + 16 * k)));
		write_pool(17'd0);
		send(make(1'b0, 16'd1, 16'd0));
		write_pool(17'h1ffff);
		send(make(1'b0, 16'hfffc, 16'd0));
		write_pool(17'd300);
		random_phase(450, 0, 0, 40);
		write_pool(17'd2000);
		random_phase(450, 49, 0, 200);
		write_pool(17'h10000);
		random_phase(450, 0, 49, 8000);
		write_pool(17'd1);
		send(make(1'b1, 16'($urandom), 16'($urandom)));
		write_pool(17'd600);
		random_phase(450, 25, 25, 60);
		drain();

		$display("sent %0d requests, checked %0d responses over several pool sizes",
			sent, sb.checked);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/ffea_pkg.sv
rtl/core/first_fit_extent_allocator_unit.sv
rtl/core/ffea_checker.sv
dv/testbench.sv
